[hdl/mvbs_pkg.sv]
// Shared types and codes for the multivariable variance/bias statistic block.
// No dependencies.
package mvbs_pkg;

    // Result kind codes
    localparam logic [1:0] RK_VAR  = 2'd0;
    localparam logic [1:0] RK_CORR = 2'd1;
    localparam logic [1:0] RK_BIAS = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // Input kind codes
    localparam logic KIND_ELEM  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Q16.16 constants
    localparam logic signed [31:0] Q_NEG_ONE = -32'sd65536;
    localparam logic signed [31:0] Q_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;
    localparam logic signed [63:0] A_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] A_MIN     = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } t_q32;

    typedef struct packed {
        logic               sat;
        logic signed [63:0] val;
    } t_acc;

endpackage

[hdl/mvbs_if.sv]
// Valid/ready channel interfaces for the input items and the result items.
// Depends on nothing.
interface mvbs_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [31:0] matrix_value;
    logic signed [31:0] residual;

    modport source (output valid, kind, row_index, col_index, matrix_value, residual,
                    input ready);
    modport sink   (input valid, kind, row_index, col_index, matrix_value, residual,
                    output ready);
endinterface

interface mvbs_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic [1:0]         out_row;
    logic [1:0]         out_col;
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic               last;

    modport source (output valid, result_kind, out_row, out_col, result_value, status, last,
                    input ready);
    modport sink   (input valid, result_kind, out_row, out_col, result_value, status, last,
                    output ready);
endinterface

[hdl/multivariable_variance_bias_stat.sv]
// Top level: slice-wise variance, correction vector and bias accumulator.
// Depends on mvbs_pkg and the channel interfaces in mvbs_if.sv.
//
//  channel   | dir | transfer when       | carries
//  i_item    | in  | valid && ready      | kind, row/col index, element, residual
//  o_res     | out | valid && ready      | kind, row/col, value, status, last
//  cfg       | in  | i_cfg_we            | theta register index and data
//
// An Mxx element passes three products through the one shared 32x32 multiplier and its
// round/accumulate step, an outcome row or column element two, an out-of-range one none.
// The slice-end element adds P+1 result transfers, then e*e, v*v and the 31-step
// restoring divider (skipped when the weight saturates), the bias update of all P*P
// entries and a clear step; a zero variance goes straight to the clear step. A flush emits
// P*P results. Reset is synchronous and active low and clears all accumulators at once.
// A stalled output holds the sequencer at its emit step.
module multivariable_variance_bias_stat
    import mvbs_pkg::*;
#(
    parameter int NUM_EXPOSURES = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mvbs_in_if.sink            i_item,
    mvbs_out_if.source         o_res,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic signed [31:0] i_cfg_data
);

    localparam logic [2:0] P3      = 3'(NUM_EXPOSURES);
    localparam logic [1:0] LAST_IX = 2'(NUM_EXPOSURES - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_M1, S_R1, S_M2, S_A2, S_M3, S_A3, S_EV, S_EH,
        S_E2, S_V2, S_DSET, S_DIV, S_BM, S_BA, S_CLR, S_FL
    } t_state;

    t_state r_state;

    logic signed [31:0] r_theta [4];
    logic signed [31:0] r_stored [16];
    logic signed [63:0] r_var;
    logic               r_var_sat;
    logic signed [63:0] r_corr [4];
    logic [3:0]         r_corr_sat;
    logic signed [63:0] r_bias [16];
    logic [15:0]        r_bias_sat;

    // latched item
    logic [2:0]         r_r, r_c;
    logic signed [31:0] r_m, r_e;

    // shared unit and sequencer registers
    logic signed [63:0] r_prod;
    logic signed [31:0] r_t;
    logic signed [31:0] r_v;
    logic               r_vz;
    logic [63:0]        r_num;
    logic [62:0]        r_den;
    logic [62:0]        r_rem;
    logic [30:0]        r_bits;
    logic [30:0]        r_q;
    logic               r_ws;
    logic [4:0]         r_cnt;
    logic [1:0]         r_i, r_j;

    // output register
    logic               r_o_valid;
    logic [1:0]         r_o_kind, r_o_row, r_o_col, r_o_stat;
    logic signed [31:0] r_o_val;
    logic               r_o_last;

    function automatic logic signed [31:0] weight(input logic [2:0] ix,
                                                  input logic signed [31:0] th [4]);
        weight = (ix < P3) ? th[ix[1:0]] : Q_NEG_ONE;
    endfunction

    function automatic t_q32 clamp(input logic signed [63:0] x);
        t_q32 q;
        if (x > 64'(Q_MAX)) begin
            q.sat = 1'b1; q.val = Q_MAX;
        end else if (x < 64'(Q_MIN)) begin
            q.sat = 1'b1; q.val = Q_MIN;
        end else begin
            q.sat = 1'b0; q.val = x[31:0];
        end
        return q;
    endfunction

    // round half up to Q16.16, then saturate
    function automatic t_q32 rnd(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = (p + 64'sd32768) >>> 16;
        return clamp(s);
    endfunction

    function automatic t_acc add64(input logic signed [63:0] a, input logic signed [63:0] b);
        logic signed [64:0] s;
        t_acc o;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            o.sat = 1'b1; o.val = s[64] ? A_MIN : A_MAX;
        end else begin
            o.sat = 1'b0; o.val = s[63:0];
        end
        return o;
    endfunction

    // shared multiplier operand select
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic [3:0]         bix;
    assign bix = {r_i, r_j};

    always_comb begin
        case (r_state)
            S_M1:    begin mul_a = weight(r_r, r_theta); mul_b = r_m;                 end
            S_M2:    begin mul_a = r_t;                  mul_b = weight(r_c, r_theta); end
            S_M3:    begin mul_a = r_m;                  mul_b = r_theta[r_c[1:0]];   end
            S_E2:    begin mul_a = r_e;                  mul_b = r_e;                 end
            S_V2:    begin mul_a = r_v;                  mul_b = r_v;                 end
            S_BM:    begin mul_a = r_stored[bix];        mul_b = {1'b0, r_q};         end
            default: begin mul_a = '0;                   mul_b = '0;                  end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // round/accumulate helpers for the current product
    t_q32 pr;
    t_acc var_add, corr_add, corr_sub, bias_add;
    t_q32 v_cl, h_cl, b_cl;
    logic [63:0] trial;
    logic        ge;

    always_comb begin
        pr       = rnd(r_prod);
        var_add  = add64(r_var, 64'(pr.val));
        corr_add = add64(r_corr[r_r[1:0]], 64'(pr.val));
        corr_sub = add64(r_corr[r_r[1:0]], -64'(r_m));
        bias_add = add64(r_bias[bix], 64'(pr.val));
        v_cl     = clamp(r_var);
        h_cl     = clamp(r_corr[r_i]);
        b_cl     = clamp(r_bias[bix]);
        trial    = {r_rem, r_bits[30]};
        ge       = trial >= {1'b0, r_den};
    end

    logic slot_free;
    assign slot_free = !r_o_valid || o_res.ready;

    // a result is loaded into the output register this cycle
    logic emit_now;
    assign emit_now = slot_free && (r_state == S_EV || r_state == S_EH || r_state == S_FL);

    assign i_item.ready = (r_state == S_IDLE);

    assign o_res.valid        = r_o_valid;
    assign o_res.result_kind  = r_o_kind;
    assign o_res.out_row      = r_o_row;
    assign o_res.out_col      = r_o_col;
    assign o_res.result_value = r_o_val;
    assign o_res.status       = r_o_stat;
    assign o_res.last         = r_o_last;

    // sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_o_valid  <= 1'b0;
            r_var      <= '0;
            r_var_sat  <= 1'b0;
            r_corr_sat <= '0;
            r_bias_sat <= '0;
            for (int k = 0; k < 4; k++) begin
                r_theta[k] <= '0;
                r_corr[k]  <= '0;
            end
            for (int k = 0; k < 16; k++) r_bias[k] <= '0;
        end else begin
            if (i_cfg_we) r_theta[i_cfg_idx] <= i_cfg_data;
            if (r_o_valid && o_res.ready && !emit_now) r_o_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_r <= i_item.row_index;
                        r_c <= i_item.col_index;
                        r_m <= i_item.matrix_value;
                        r_e <= i_item.residual;
                        r_i <= '0;
                        r_j <= '0;
                        if (i_item.kind == KIND_FLUSH) begin
                            r_state <= S_FL;
                        end else if (i_item.row_index <= P3 && i_item.col_index <= P3) begin
                            r_state <= S_M1;
                        end
                    end
                end
                S_M1: begin
                    r_prod  <= mul_p;
                    r_state <= S_R1;
                end
                S_R1: begin
                    r_t <= pr.val;
                    if (pr.sat) r_var_sat <= 1'b1;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_prod  <= mul_p;
                    r_state <= S_A2;
                end
                S_A2: begin
                    r_var <= var_add.val;
                    if (pr.sat || var_add.sat) r_var_sat <= 1'b1;
                    if (r_r < P3 && r_c < P3) begin
                        r_stored[{r_r[1:0], r_c[1:0]}] <= r_m;
                        r_state <= S_M3;
                    end else if (r_r < P3) begin
                        r_corr[r_r[1:0]] <= corr_sub.val;
                        if (corr_sub.sat) r_corr_sat[r_r[1:0]] <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_c == P3) begin
                        r_state <= S_EV;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_M3: begin
                    r_prod  <= mul_p;
                    r_state <= S_A3;
                end
                S_A3: begin
                    r_corr[r_r[1:0]] <= corr_add.val;
                    if (pr.sat || corr_add.sat) r_corr_sat[r_r[1:0]] <= 1'b1;
                    r_state <= S_IDLE;
                end
                // emit v
                S_EV: begin
                    if (slot_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= RK_VAR;
                        r_o_row   <= '0;
                        r_o_col   <= '0;
                        r_o_val   <= v_cl.val;
                        r_o_stat  <= (v_cl.val == 0) ? ST_ZERO :
                                     ((v_cl.sat || r_var_sat) ? ST_SAT : ST_OK);
                        r_o_last  <= 1'b0;
                        r_v       <= v_cl.val;
                        r_vz      <= (v_cl.val == 0);
                        r_i       <= '0;
                        r_state   <= S_EH;
                    end
                end
                // emit h[0..P-1]
                S_EH: begin
                    if (slot_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= RK_CORR;
                        r_o_row   <= r_i;
                        r_o_col   <= '0;
                        r_o_val   <= h_cl.val;
                        r_o_stat  <= (h_cl.sat || r_corr_sat[r_i]) ? ST_SAT : ST_OK;
                        r_o_last  <= (r_i == LAST_IX);
                        if (r_i == LAST_IX) begin
                            r_i     <= '0;
                            r_j     <= '0;
                            r_state <= r_vz ? S_CLR : S_E2;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end
                end
                S_E2: begin
                    r_prod  <= mul_p;
                    r_state <= S_V2;
                end
                S_V2: begin
                    r_num   <= r_prod;
                    r_prod  <= mul_p;
                    r_state <= S_DSET;
                end
                // integer part check, then set up the fraction division
                S_DSET: begin
                    r_den  <= r_prod[62:0];
                    r_cnt  <= '0;
                    r_rem  <= {14'b0, r_num[63:15]};
                    r_bits <= {r_num[14:0], 16'b0};
                    // v*v = 2^62 only for v at the negative bound, never saturating
                    if ({13'b0, r_num} >= {r_prod[61:0], 15'b0} && !r_prod[62]) begin
                        r_q     <= '1;
                        r_ws    <= 1'b1;
                        r_state <= S_BM;
                    end else begin
                        r_q     <= '0;
                        r_ws    <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                // one quotient bit per cycle
                S_DIV: begin
                    r_rem  <= ge ? 63'(trial - {1'b0, r_den}) : trial[62:0];
                    r_bits <= {r_bits[29:0], 1'b0};
                    r_q    <= {r_q[29:0], ge};
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'd30) r_state <= S_BM;
                end
                S_BM: begin
                    r_prod  <= mul_p;
                    r_state <= S_BA;
                end
                S_BA: begin
                    r_bias[bix] <= bias_add.val;
                    if (pr.sat || r_ws || bias_add.sat) r_bias_sat[bix] <= 1'b1;
                    if (r_j == LAST_IX) begin
                        r_j <= '0;
                        if (r_i == LAST_IX) begin
                            r_state <= S_CLR;
                        end else begin
                            r_i     <= r_i + 2'd1;
                            r_state <= S_BM;
                        end
                    end else begin
                        r_j     <= r_j + 2'd1;
                        r_state <= S_BM;
                    end
                end
                S_CLR: begin
                    r_var      <= '0;
                    r_var_sat  <= 1'b0;
                    r_corr_sat <= '0;
                    for (int k = 0; k < 4; k++) r_corr[k] <= '0;
                    r_state <= S_IDLE;
                end
                // emit bias matrix row-major, then clear it
                S_FL: begin
                    if (slot_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= RK_BIAS;
                        r_o_row   <= r_i;
                        r_o_col   <= r_j;
                        r_o_val   <= b_cl.val;
                        r_o_stat  <= (b_cl.sat || r_bias_sat[bix]) ? ST_SAT : ST_OK;
                        r_o_last  <= (r_i == LAST_IX) && (r_j == LAST_IX);
                        if (r_j == LAST_IX) begin
                            r_j <= '0;
                            if (r_i == LAST_IX) begin
                                r_bias_sat <= '0;
                                for (int k = 0; k < 16; k++) r_bias[k] <= '0;
                                r_state <= S_IDLE;
                            end else begin
                                r_i <= r_i + 2'd1;
                            end
                        end else begin
                            r_j <= r_j + 2'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[hdl/mvbs_chk.sv]
// Port-level checker for the variance/bias statistic block, bound to the top level.
// Depends on mvbs_pkg.
module mvbs_chk
    import mvbs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] out_kind,
    input logic [1:0] out_row,
    input logic [1:0] out_col,
    input logic [1:0] out_status,
    input logic       out_last,
    input logic [31:0] out_value
);

    // a held result keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value))
        else $error("result dropped or changed while stalled");

    // zero-variance status only on the variance result
    a_zero_on_var: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status == ST_ZERO |-> out_kind == RK_VAR)
        else $error("zero-variance status on a non-variance result");

    // the variance result never ends a run and carries no position
    a_var_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == RK_VAR |-> !out_last && out_row == 2'd0 && out_col == 2'd0)
        else $error("malformed variance result");

    // zero-variance status matches a zero value
    a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == RK_VAR |-> ((out_value == 32'd0) == (out_status == ST_ZERO)))
        else $error("variance status does not match value");

endmodule

bind multivariable_variance_bias_stat mvbs_chk u_mvbs_chk (
    .clk        (i_clk),
    .rst_n      (i_rst_n),
    .out_valid  (o_res.valid),
    .out_ready  (o_res.ready),
    .out_kind   (o_res.result_kind),
    .out_row    (o_res.out_row),
    .out_col    (o_res.out_col),
    .out_status (o_res.status),
    .out_last   (o_res.last),
    .out_value  (o_res.result_value)
);
